@@ hw/rtl/wrm_pkg.sv @@
// Package of shared types and constants for the weighted rule mixer.
`timescale 1ns / 1ps

package wrm_pkg;

   localparam int AXIS_W      = 16;
   localparam int RULE_SLOTS  = 8;
   localparam int PAIR_REGS   = 4;
   localparam int RULE_W      = 32;
   localparam int WEIGHT_W    = 16;
   localparam int WEIGHT_ONE  = 16384;
   localparam int ACC_W       = 35;
   localparam int FRAC_SHIFT  = 14;
   localparam int ROUND_HALF  = 8192;
   localparam int MIX_MAX     = 32767;
   localparam int MIX_MIN     = -32768;
   localparam int NUM_W       = 4;
   localparam int COUNT_W     = 5;
   localparam int SLOT_W      = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;

   // Register indexes of the write port.
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_PAIR_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_PAIR_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_PAIR_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_PAIR_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_COUNT = 3'd5;

   // Source axis codes held in a rule.
   localparam logic [1:0] SRC_THROTTLE = 2'd0;
   localparam logic [1:0] SRC_PITCH    = 2'd1;
   localparam logic [1:0] SRC_ROLL     = 2'd2;
   localparam logic [1:0] SRC_YAW      = 2'd3;

   // Target kind codes.
   localparam logic KIND_MOTOR = 1'b0;
   localparam logic KIND_SERVO = 1'b1;

   typedef struct packed {
      logic signed [AXIS_W-1:0] throttle_in;
      logic signed [AXIS_W-1:0] pitch_in;
      logic signed [AXIS_W-1:0] roll_in;
      logic signed [AXIS_W-1:0] yaw_in;
   } req_type;

   typedef struct packed {
      logic                     target_kind;
      logic [SLOT_W-1:0]        target_slot;
      logic signed [AXIS_W-1:0] mix_value;
      logic                     clipped;
      logic                     last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [RULE_SLOTS-1:0][RULE_W-1:0] rule_word;
      logic [NUM_W-1:0]                  motor_num;
      logic [NUM_W-1:0]                  servo_num;
   } cfg_type;

   typedef struct packed {
      logic                       enable;
      logic                       kind;
      logic [SLOT_W-1:0]          index;
      logic [1:0]                 source;
      logic signed [WEIGHT_W-1:0] weight;
   } rule_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } back_state_type;

   function automatic rule_type rule_decode(input logic [RULE_W-1:0] word);
      rule_type r;
      r.enable = word[0];
      r.kind   = word[1];
      r.index  = word[4:2];
      r.source = word[6:5];
      r.weight = word[22:7];
      return r;
   endfunction

endpackage

@@ hw/rtl/wrm_front.sv @@
// Front end: takes input beats, drops those that cause no result, feeds the queue.
`timescale 1ns / 1ps

module wrm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wrm_pkg::req_type req_data,
   input  wrm_pkg::cfg_type cfg,
   input  logic             q_full,
   output logic             q_push,
   output wrm_pkg::req_type q_push_data
);

   logic             hold_vld_ff, hold_vld_in;
   wrm_pkg::req_type hold_data_ff;
   logic             no_output;
   logic             leave;
   logic             accept;

   // With both counts at zero an item produces nothing and is retired here.
   assign no_output   = (cfg.motor_num == '0) && (cfg.servo_num == '0);
   assign leave       = hold_vld_ff && (no_output || !q_full);
   assign req_ready   = !hold_vld_ff || leave;
   assign accept      = req_valid && req_ready;
   assign q_push      = hold_vld_ff && !no_output && !q_full;
   assign q_push_data = hold_data_ff;

   always_comb begin
      hold_vld_in = hold_vld_ff;
      if (accept) begin
         hold_vld_in = 1'b1;
      end else if (leave) begin
         hold_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_data_ff <= req_data;
      end
   end

endmodule

@@ hw/rtl/wrm_queue.sv @@
// Short queue of accepted items between the front end and the mixing engine.
`timescale 1ns / 1ps

module wrm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wrm_pkg::req_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output wrm_pkg::req_type head_data
);

   localparam int PTR_W = (wrm_pkg::QUEUE_DEPTH > 1) ? $clog2(wrm_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(wrm_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(wrm_pkg::QUEUE_DEPTH - 1);

   wrm_pkg::req_type entry_ff [wrm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == CNT_W'(wrm_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/wrm_back.sv @@
// Engine: one rule per cycle into per-output sums, then one result per cycle unless stalled.
`timescale 1ns / 1ps

module wrm_back #(
   parameter int RULES  = 8,
   parameter int MOTORS = 8,
   parameter int SERVOS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  wrm_pkg::cfg_type cfg,
   input  logic             q_not_empty,
   input  wrm_pkg::req_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wrm_pkg::rsp_type rsp_data
);

   localparam int LANES  = MOTORS + SERVOS;
   localparam int LANE_W = $clog2(LANES);
   localparam int RCNT_W = $clog2(RULES + 1);
   localparam int CW     = wrm_pkg::COUNT_W;
   localparam int Q_W    = wrm_pkg::ACC_W - wrm_pkg::FRAC_SHIFT + 1;

   wrm_pkg::back_state_type state_ff, state_in;

   logic                            pop_go, mac_go, emit_step;
   logic [RCNT_W-1:0]               rule_ff, rule_in;
   logic [CW-1:0]                   emit_ff, emit_in;
   wrm_pkg::req_type                axes_ff;
   logic signed [wrm_pkg::ACC_W-1:0] acc_ff [LANES];
   logic signed [wrm_pkg::ACC_W-1:0] acc_in [LANES];
   logic                            prod_vld_ff, prod_vld_in;
   logic signed [31:0]              prod_ff, prod_in;
   logic [LANE_W-1:0]               lane_ff, lane_in;
   logic                            rsp_vld_ff, rsp_vld_in;
   wrm_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                            rule_last, last_emit;
   wrm_pkg::rule_type               rule;
   logic                            rule_ok;
   logic [wrm_pkg::NUM_W-1:0]       kind_num;
   logic signed [wrm_pkg::AXIS_W-1:0] axis_sel;
   logic [CW-1:0]                   rule_lane5;
   logic [CW-1:0]                   total, slot5, out_lane5;
   logic                            out_kind;
   logic signed [wrm_pkg::ACC_W-1:0] acc_sel;
   logic signed [wrm_pkg::ACC_W:0]   rnd_sum;
   logic signed [Q_W-1:0]            q_val;

   assign rule_last = (rule_ff == RCNT_W'(RULES - 1));
   assign total     = CW'(cfg.motor_num) + CW'(cfg.servo_num);
   assign last_emit = (emit_ff == total - CW'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wrm_pkg::ST_IDLE: begin
            if (q_not_empty) begin
               state_in = wrm_pkg::ST_MAC;
            end
         end
         wrm_pkg::ST_MAC: begin
            if (rule_last) begin
               state_in = wrm_pkg::ST_DRAIN;
            end
         end
         wrm_pkg::ST_DRAIN: begin
            state_in = wrm_pkg::ST_EMIT;
         end
         wrm_pkg::ST_EMIT: begin
            if (emit_step && last_emit) begin
               state_in = wrm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wrm_pkg::ST_IDLE;
         end
      endcase
   end

   // Control strobes.
   always_comb begin
      pop_go    = 1'b0;
      mac_go    = 1'b0;
      emit_step = 1'b0;
      case (state_ff)
         wrm_pkg::ST_IDLE: begin
            pop_go = q_not_empty;
         end
         wrm_pkg::ST_MAC: begin
            mac_go = 1'b1;
         end
         wrm_pkg::ST_DRAIN: begin
         end
         wrm_pkg::ST_EMIT: begin
            emit_step = !rsp_vld_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   assign q_pop = pop_go;

   // Rule decode and product for the rule in hand.
   always_comb begin
      rule     = wrm_pkg::rule_decode(cfg.rule_word[3'(rule_ff)]);
      kind_num = (rule.kind == wrm_pkg::KIND_SERVO) ? cfg.servo_num : cfg.motor_num;
      rule_ok  = (32'(rule_ff) < wrm_pkg::RULE_SLOTS) && rule.enable &&
                 (rule.weight >= -16'(wrm_pkg::WEIGHT_ONE)) &&
                 (rule.weight <= 16'(wrm_pkg::WEIGHT_ONE)) &&
                 ({1'b0, rule.index} < kind_num);
      case (rule.source)
         wrm_pkg::SRC_THROTTLE: axis_sel = axes_ff.throttle_in;
         wrm_pkg::SRC_PITCH:    axis_sel = axes_ff.pitch_in;
         wrm_pkg::SRC_ROLL:     axis_sel = axes_ff.roll_in;
         wrm_pkg::SRC_YAW:      axis_sel = axes_ff.yaw_in;
         default:               axis_sel = axes_ff.throttle_in;
      endcase
      prod_in     = axis_sel * rule.weight;
      rule_lane5  = (rule.kind == wrm_pkg::KIND_SERVO) ?
                    CW'(MOTORS) + CW'(rule.index) : CW'(rule.index);
      lane_in     = rule_lane5[LANE_W-1:0];
      prod_vld_in = mac_go && rule_ok;
      rule_in     = pop_go ? '0 : (mac_go ? rule_ff + 1'b1 : rule_ff);
   end

   // Each lane keeps its own adder.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         acc_in[i] = acc_ff[i];
         if (pop_go) begin
            acc_in[i] = '0;
         end else if (prod_vld_ff && (lane_ff == LANE_W'(i))) begin
            acc_in[i] = acc_ff[i] + wrm_pkg::ACC_W'(prod_ff);
         end
      end
   end

   // Result for the current emit position: round half up, then saturate.
   always_comb begin
      out_kind  = (emit_ff >= CW'(cfg.motor_num));
      slot5     = out_kind ? emit_ff - CW'(cfg.motor_num) : emit_ff;
      out_lane5 = out_kind ? CW'(MOTORS) + slot5 : slot5;
      acc_sel   = acc_ff[out_lane5[LANE_W-1:0]];
      rnd_sum   = (wrm_pkg::ACC_W + 1)'(acc_sel) +
                  (wrm_pkg::ACC_W + 1)'(wrm_pkg::ROUND_HALF);
      q_val     = rnd_sum[wrm_pkg::ACC_W:wrm_pkg::FRAC_SHIFT];

      rsp_data_in             = rsp_data_ff;
      rsp_data_in.target_kind = out_kind;
      rsp_data_in.target_slot = slot5[wrm_pkg::SLOT_W-1:0];
      rsp_data_in.last_of_run = last_emit;
      if (q_val > Q_W'(wrm_pkg::MIX_MAX)) begin
         rsp_data_in.mix_value = 16'(wrm_pkg::MIX_MAX);
         rsp_data_in.clipped   = 1'b1;
      end else if (q_val < Q_W'(wrm_pkg::MIX_MIN)) begin
         rsp_data_in.mix_value = 16'(wrm_pkg::MIX_MIN);
         rsp_data_in.clipped   = 1'b1;
      end else begin
         rsp_data_in.mix_value = q_val[wrm_pkg::AXIS_W-1:0];
         rsp_data_in.clipped   = 1'b0;
      end

      emit_in    = pop_go ? '0 : (emit_step ? emit_ff + 1'b1 : emit_ff);
      rsp_vld_in = emit_step ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= wrm_pkg::ST_IDLE;
         rule_ff     <= '0;
         emit_ff     <= '0;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rule_ff     <= rule_in;
         emit_ff     <= emit_in;
         prod_vld_ff <= prod_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_go) begin
         axes_ff <= q_head;
      end
      prod_ff <= prod_in;
      lane_ff <= lane_in;
      for (int i = 0; i < LANES; i++) begin
         acc_ff[i] <= acc_in[i];
      end
      if (emit_step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ hw/rtl/weighted_rule_mixer.sv @@
// Top level of the weighted rule mixer: register file, front end, queue and mixing engine.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake              Beat
//  req_      in         req_valid / req_ready  throttle, pitch, roll and yaw, Q1.15
//  rsp_      out        rsp_valid / rsp_ready  one mixed motor or servo value
//  csr_      in         csr_wr_en              register index and 64-bit write data
//
//  An item whose counts are both zero is retired in the front end and causes no beat.
//  Otherwise the engine applies each of the RULES rules through its single multiplier,
//  drains the product register, then writes each result into the output register and
//  picks up the next item. Reset is synchronous and clears the register file and all
//  control state.
//  The queue lets the front end keep taking beats while the engine stalls on rsp_ready.

module weighted_rule_mixer #(
   parameter int RULES  = 8,
   parameter int MOTORS = 8,
   parameter int SERVOS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  wrm_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output wrm_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [wrm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wrm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Register file. Indexes beyond the servo count register are ignored.
   logic [wrm_pkg::CSR_DATA_W-1:0] rule_pair_ff [wrm_pkg::PAIR_REGS];
   logic [wrm_pkg::NUM_W-1:0]      motor_count_ff;
   logic [wrm_pkg::NUM_W-1:0]      servo_count_ff;

   wrm_pkg::cfg_type cfg;
   logic             q_full, q_push, q_pop, q_not_empty;
   wrm_pkg::req_type q_push_data, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < wrm_pkg::PAIR_REGS; p++) begin
            rule_pair_ff[p] <= '0;
         end
         motor_count_ff <= '0;
         servo_count_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            wrm_pkg::CSR_RULE_PAIR_0: rule_pair_ff[0] <= csr_wdata;
            wrm_pkg::CSR_RULE_PAIR_1: rule_pair_ff[1] <= csr_wdata;
            wrm_pkg::CSR_RULE_PAIR_2: rule_pair_ff[2] <= csr_wdata;
            wrm_pkg::CSR_RULE_PAIR_3: rule_pair_ff[3] <= csr_wdata;
            wrm_pkg::CSR_MOTOR_COUNT: motor_count_ff <= csr_wdata[wrm_pkg::NUM_W-1:0];
            wrm_pkg::CSR_SERVO_COUNT: servo_count_ff <= csr_wdata[wrm_pkg::NUM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Each pair register holds its even rule in the low half and its odd rule in the high
   // half. Counts larger than the number of outputs built are held at that number.
   always_comb begin
      for (int p = 0; p < wrm_pkg::PAIR_REGS; p++) begin
         cfg.rule_word[2*p]     = rule_pair_ff[p][wrm_pkg::RULE_W-1:0];
         cfg.rule_word[2*p + 1] = rule_pair_ff[p][2*wrm_pkg::RULE_W-1:wrm_pkg::RULE_W];
      end
      cfg.motor_num = (motor_count_ff > wrm_pkg::NUM_W'(MOTORS)) ?
                      wrm_pkg::NUM_W'(MOTORS) : motor_count_ff;
      cfg.servo_num = (servo_count_ff > wrm_pkg::NUM_W'(SERVOS)) ?
                      wrm_pkg::NUM_W'(SERVOS) : servo_count_ff;
   end

   wrm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .cfg         (cfg),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   wrm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   wrm_back #(
      .RULES  (RULES),
      .MOTORS (MOTORS),
      .SERVOS (SERVOS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
